// File: src/packet_queue_xor_framer_defines.svh
// Assertion macros for the packet queue framer.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef PACKET_QUEUE_XOR_FRAMER_DEFINES_SVH
`define PACKET_QUEUE_XOR_FRAMER_DEFINES_SVH

// Same-cycle implication, off during reset.
`define PQXF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define PQXF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/pqxf_pkg.sv
// Shared types and constants for the packet queue framer.
// No dependencies; imported by the front, back and top level.
package pqxf_pkg;

  localparam int SLOTS_DEF       = 64;
  localparam int PAYLOAD_MAX_DEF = 64;
  localparam int QDEPTH          = 4;
  localparam int QAW             = $clog2(QDEPTH);

  localparam logic [7:0] SYNC_FIRST  = 8'hA5;
  localparam logic [7:0] SYNC_SECOND = 8'h5A;

  typedef enum logic [2:0] {
    OP_RX      = 3'b001,
    OP_RX_LAST = 3'b010,
    OP_TX      = 3'b100
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic phase_idle;
    logic ring_empty;
  } back_status_t;

endpackage

// File: src/pqxf_front.sv
// Front end: accepts items, classifies them and queues them for the back end.
// Depends on pqxf_pkg.
module pqxf_front
  import pqxf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_kind,
  input  logic [7:0] in_rx_byte,
  input  logic       in_rx_last,
  output logic       q_valid,
  output item_t      q_item,
  input  logic       q_pop
);

  item_t            fifo_r [QDEPTH];
  logic [QAW-1:0]   wr_r, wr_nxt;
  logic [QAW-1:0]   rd_r, rd_nxt;
  logic [QAW:0]     cnt_r, cnt_nxt;
  logic             push, pop;
  item_t            new_item;

  assign in_stall = (cnt_r == (QAW+1)'(QDEPTH));
  assign q_valid  = (cnt_r != '0);
  assign q_item   = fifo_r[rd_r];
  assign push     = in_valid && !in_stall;
  assign pop      = q_pop && q_valid;

  always_comb begin
    new_item.data = in_rx_byte;
    priority if (in_kind) begin
      new_item.op = OP_TX;
    end else if (in_rx_last) begin
      new_item.op = OP_RX_LAST;
    end else begin
      new_item.op = OP_RX;
    end
  end

  always_comb begin
    wr_nxt  = push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + (QAW+1)'(push) - (QAW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_r] <= new_item;
    end
  end

endmodule

// File: src/pqxf_back.sv
// Back end: packet ring, slot lengths, frame sequencer and output register.
// Depends on pqxf_pkg; fed by pqxf_front.
module pqxf_back
  import pqxf_pkg::*;
#(
  parameter int SLOTS       = SLOTS_DEF,
  parameter int PAYLOAD_MAX = PAYLOAD_MAX_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         q_valid,
  input  item_t        q_item,
  output logic         q_pop,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [7:0]   out_tx_byte,
  output logic         out_frame_end,
  output back_status_t status
);

  localparam int SW    = $clog2(SLOTS);
  localparam int IW    = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;
  localparam int RCW   = $clog2(PAYLOAD_MAX + 1);
  localparam int DEPTH = SLOTS * (2 ** IW);
  localparam int AW    = SW + IW;
  localparam logic [RCW-1:0] PM_C   = RCW'(PAYLOAD_MAX);
  localparam logic [SW-1:0]  LAST_S = SW'(SLOTS - 1);

  typedef enum logic [4:0] {
    PH_IDLE  = 5'b00001,
    PH_SYNC2 = 5'b00010,
    PH_LEN   = 5'b00100,
    PH_DATA  = 5'b01000,
    PH_CHECK = 5'b10000
  } phase_t;

  typedef enum logic [1:0] {
    OS_CONST = 2'd0,
    OS_LEN   = 2'd1,
    OS_DATA  = 2'd2,
    OS_CHECK = 2'd3
  } osrc_t;

  logic [7:0]     pkt_mem [DEPTH];
  logic [RCW-1:0] len_mem [SLOTS];

  logic [SW-1:0]  wslot_r, wslot_nxt, rslot_r, rslot_nxt;
  logic           wwrap_r, wwrap_nxt, rwrap_r, rwrap_nxt;
  logic [RCW-1:0] rcnt_r, rcnt_nxt;
  logic           drop_r, drop_nxt;
  phase_t         ph_r, ph_nxt;
  logic [RCW-1:0] pidx_r, pidx_nxt, pidx_inc;
  logic [7:0]     chk_r;
  logic           o_valid_r;
  osrc_t          o_src_r, o_src_nxt;
  logic [7:0]     o_byte_r, o_byte_nxt;
  logic           o_end_r, o_end_nxt;
  logic [RCW-1:0] len_q_r;
  logic [7:0]     rd_data_r;

  logic           ring_full, ring_empty, is_tx, adv, o_take;
  logic           drop_v, wr_ok, commit, emit, rd_req;
  logic [RCW-1:0] cnt_v;
  logic [AW-1:0]  wr_addr, rd_addr;

  assign ring_full  = (wslot_r == rslot_r) && (wwrap_r != rwrap_r);
  assign ring_empty = (wslot_r == rslot_r) && (wwrap_r == rwrap_r);
  assign is_tx      = (q_item.op == OP_TX);
  assign o_take     = o_valid_r && !out_stall;
  assign adv        = q_valid && (!is_tx || !o_valid_r || !out_stall);
  assign q_pop      = adv;
  assign wr_addr    = {wslot_r, rcnt_r[IW-1:0]};
  assign rd_addr    = {rslot_r, pidx_r[IW-1:0]};
  assign pidx_inc   = pidx_r + 1'b1;

  always_comb begin
    drop_v = drop_r;
    cnt_v  = rcnt_r;
    wr_ok  = 1'b0;
    commit = 1'b0;
    if (rcnt_r == '0 && !drop_r && ring_full) begin
      drop_v = 1'b1;
    end
    if (!drop_v) begin
      if (rcnt_r >= PM_C) begin
        drop_v = 1'b1;
      end else begin
        wr_ok = 1'b1;
        cnt_v = rcnt_r + 1'b1;
      end
    end
    if (q_item.op == OP_RX_LAST && !drop_v && cnt_v != '0) begin
      commit = 1'b1;
    end
  end

  always_comb begin
    wslot_nxt  = wslot_r;
    wwrap_nxt  = wwrap_r;
    rslot_nxt  = rslot_r;
    rwrap_nxt  = rwrap_r;
    rcnt_nxt   = rcnt_r;
    drop_nxt   = drop_r;
    ph_nxt     = ph_r;
    pidx_nxt   = pidx_r;
    emit       = 1'b0;
    rd_req     = 1'b0;
    o_src_nxt  = OS_CONST;
    o_byte_nxt = SYNC_FIRST;
    o_end_nxt  = 1'b0;
    if (adv && !is_tx) begin
      if (q_item.op == OP_RX_LAST) begin
        rcnt_nxt = '0;
        drop_nxt = 1'b0;
        if (commit) begin
          if (wslot_r == LAST_S) begin
            wslot_nxt = '0;
            wwrap_nxt = ~wwrap_r;
          end else begin
            wslot_nxt = wslot_r + 1'b1;
          end
        end
      end else begin
        rcnt_nxt = cnt_v;
        drop_nxt = drop_v;
      end
    end
    if (adv && is_tx) begin
      unique case (ph_r)
        PH_IDLE: begin
          if (!ring_empty) begin
            emit   = 1'b1;
            ph_nxt = PH_SYNC2;
          end
        end
        PH_SYNC2: begin
          emit       = 1'b1;
          o_byte_nxt = SYNC_SECOND;
          ph_nxt     = PH_LEN;
        end
        PH_LEN: begin
          emit       = 1'b1;
          o_src_nxt  = OS_LEN;
          o_byte_nxt = 8'(len_q_r);
          pidx_nxt   = '0;
          ph_nxt     = (len_q_r == '0) ? PH_CHECK : PH_DATA;
        end
        PH_DATA: begin
          emit      = 1'b1;
          rd_req    = 1'b1;
          o_src_nxt = OS_DATA;
          pidx_nxt  = pidx_inc;
          if (pidx_inc >= len_q_r || pidx_inc >= PM_C) begin
            ph_nxt = PH_CHECK;
          end
        end
        PH_CHECK: begin
          emit      = 1'b1;
          o_src_nxt = OS_CHECK;
          o_end_nxt = 1'b1;
          pidx_nxt  = '0;
          ph_nxt    = PH_IDLE;
          if (rslot_r == LAST_S) begin
            rslot_nxt = '0;
            rwrap_nxt = ~rwrap_r;
          end else begin
            rslot_nxt = rslot_r + 1'b1;
          end
        end
        default: begin
          ph_nxt = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wslot_r   <= '0;
      wwrap_r   <= 1'b0;
      rslot_r   <= '0;
      rwrap_r   <= 1'b0;
      rcnt_r    <= '0;
      drop_r    <= 1'b0;
      ph_r      <= PH_IDLE;
      pidx_r    <= '0;
      chk_r     <= '0;
      o_valid_r <= 1'b0;
    end else begin
      wslot_r <= wslot_nxt;
      wwrap_r <= wwrap_nxt;
      rslot_r <= rslot_nxt;
      rwrap_r <= rwrap_nxt;
      rcnt_r  <= rcnt_nxt;
      drop_r  <= drop_nxt;
      ph_r    <= ph_nxt;
      pidx_r  <= pidx_nxt;
      if (o_take) begin
        unique case (o_src_r)
          OS_LEN:  chk_r <= o_byte_r;
          OS_DATA: chk_r <= chk_r ^ rd_data_r;
          default: chk_r <= chk_r;
        endcase
      end
      if (emit) begin
        o_valid_r <= 1'b1;
      end else if (o_take) begin
        o_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      o_src_r  <= o_src_nxt;
      o_byte_r <= o_byte_nxt;
      o_end_r  <= o_end_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && !is_tx && wr_ok) begin
      pkt_mem[wr_addr] <= q_item.data;
    end
    if (rd_req) begin
      rd_data_r <= pkt_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (adv && commit) begin
      len_mem[wslot_r] <= cnt_v;
    end
    len_q_r <= len_mem[rslot_nxt];
  end

  always_comb begin
    unique case (o_src_r)
      OS_DATA:  out_tx_byte = rd_data_r;
      OS_CHECK: out_tx_byte = chk_r;
      default:  out_tx_byte = o_byte_r;
    endcase
  end

  assign out_valid         = o_valid_r;
  assign out_frame_end     = o_end_r;
  assign status.phase_idle = (ph_r == PH_IDLE);
  assign status.ring_empty = ring_empty;

endmodule

// File: src/packet_queue_xor_framer.sv
// Packet queue framer: one item per cycle sustained, any mix of kinds, while
// out_stall stays low. A transmit item that yields a byte passes through the
// front queue and then the sequencer's output register before it shows on out_;
// payload bytes come from the registered payload memory read, loaded alongside.
// Reset (synchronous, rst_n low) empties the ring and queue and idles the framer;
// payload and length stores keep their contents and need no clearing pass.
`include "packet_queue_xor_framer_defines.svh"

module packet_queue_xor_framer
  import pqxf_pkg::*;
#(
  parameter int SLOTS       = SLOTS_DEF,
  parameter int PAYLOAD_MAX = PAYLOAD_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_kind,
  input  logic [7:0] in_rx_byte,
  input  logic       in_rx_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_tx_byte,
  output logic       out_frame_end
);

  logic         q_valid;
  item_t        q_item;
  logic         q_pop;
  back_status_t status;

  pqxf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_kind    (in_kind),
    .in_rx_byte (in_rx_byte),
    .in_rx_last (in_rx_last),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop)
  );

  pqxf_back #(
    .SLOTS       (SLOTS),
    .PAYLOAD_MAX (PAYLOAD_MAX)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_tx_byte   (out_tx_byte),
    .out_frame_end (out_frame_end),
    .status        (status)
  );

  `PQXF_ASSERT_NOW(a_stall_has_items, in_stall, q_valid, "stall with empty queue")
  `PQXF_ASSERT_NEXT(a_queue_holds, q_valid && !q_pop, q_valid, "queued item lost")
  `PQXF_ASSERT_NOW(a_end_idle, out_valid && out_frame_end, status.phase_idle, "frame end not idle")
  `PQXF_ASSERT_NOW(a_frame_has_pkt, !status.phase_idle, !status.ring_empty, "frame with empty ring")

endmodule

// File: sim/tb_top.sv
// Testbench for packet_queue_xor_framer: random packet bytes and transmit slots,
// with an item-level predictor of the packet ring and the sync/length/XOR framer.
// Depends on pqxf_pkg and the packet_queue_xor_framer top level.
`timescale 1ns / 100ps

module tb_top;
  import pqxf_pkg::SLOTS_DEF;
  import pqxf_pkg::PAYLOAD_MAX_DEF;
  import pqxf_pkg::SYNC_FIRST;
  import pqxf_pkg::SYNC_SECOND;

  localparam int SLOTS       = SLOTS_DEF;
  localparam int PAYLOAD_MAX = PAYLOAD_MAX_DEF;
  localparam int QUIET_LIMIT = 4000;
  localparam int RANDOM_ITEMS = 500;

  localparam logic KIND_RX = 1'b0;
  localparam logic KIND_TX = 1'b1;

  typedef enum logic [2:0] {
    FR_IDLE  = 3'd0,
    FR_SYNC2 = 3'd1,
    FR_LEN   = 3'd2,
    FR_DATA  = 3'd3,
    FR_CHECK = 3'd4
  } frame_phase_t;

  typedef struct {
    logic       kind;
    logic [7:0] data;
    logic       last;
    bit         hold;
  } link_item_t;

  typedef struct {
    logic [7:0] tx_byte;
    logic       frame_end;
  } frame_byte_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       in_kind = 1'b0;
  logic [7:0] in_rx_byte = 8'h00;
  logic       in_rx_last = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_tx_byte;
  logic       out_frame_end;

  packet_queue_xor_framer u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_kind      (in_kind),
    .in_rx_byte   (in_rx_byte),
    .in_rx_last   (in_rx_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_tx_byte  (out_tx_byte),
    .out_frame_end(out_frame_end)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  link_item_t  pending_items[$];
  frame_byte_t tx_expected[$];
  int          errors = 0;
  int          queued_items = 0;
  bit          hold_next = 1'b0;

  // ring and framer shadow state
  logic [7:0]   ring_mem [SLOTS][PAYLOAD_MAX];
  logic [6:0]   ring_len [SLOTS];
  logic [6:0]   wr_ptr = '0;
  logic [6:0]   rd_ptr = '0;
  logic [6:0]   rx_count = '0;
  logic         rx_drop = 1'b0;
  frame_phase_t phase = FR_IDLE;
  logic [6:0]   pay_idx = '0;
  logic [7:0]   chk = '0;

  function automatic int unsigned pick_gap();
    int unsigned r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  task automatic framer_predict(input logic kind, input logic [7:0] b, input logic last);
    logic [6:0]  occ;
    logic [5:0]  wslot;
    logic [5:0]  rslot;
    frame_byte_t fb;
    occ   = wr_ptr - rd_ptr;
    wslot = wr_ptr[5:0];
    rslot = rd_ptr[5:0];
    if (kind == KIND_RX) begin
      if (rx_count == 0 && !rx_drop && occ >= SLOTS) rx_drop = 1'b1;
      if (!rx_drop) begin
        if (rx_count >= PAYLOAD_MAX) begin
          rx_drop = 1'b1;
        end else begin
          ring_mem[wslot][rx_count] = b;
          rx_count++;
        end
      end
      if (last) begin
        if (!rx_drop && rx_count > 0) begin
          ring_len[wslot] = rx_count;
          wr_ptr++;
        end
        rx_count = '0;
        rx_drop  = 1'b0;
      end
    end else begin
      fb.frame_end = 1'b0;
      fb.tx_byte   = 8'h00;
      case (phase)
        FR_SYNC2: begin
          fb.tx_byte = SYNC_SECOND;
          phase = FR_LEN;
        end
        FR_LEN: begin
          fb.tx_byte = {1'b0, ring_len[rslot]};
          chk = fb.tx_byte;
          pay_idx = '0;
          phase = (ring_len[rslot] == 0) ? FR_CHECK : FR_DATA;
        end
        FR_DATA: begin
          fb.tx_byte = ring_mem[rslot][pay_idx];
          chk = chk ^ fb.tx_byte;
          pay_idx++;
          if (pay_idx >= ring_len[rslot] || pay_idx >= PAYLOAD_MAX) phase = FR_CHECK;
        end
        FR_CHECK: begin
          fb.tx_byte = chk;
          fb.frame_end = 1'b1;
          rd_ptr++;
          phase = FR_IDLE;
          pay_idx = '0;
        end
        default: begin
          if (occ != 0) begin
            fb.tx_byte = SYNC_FIRST;
            phase = FR_SYNC2;
          end
        end
      endcase
      if (phase != FR_IDLE || fb.frame_end) tx_expected.push_back(fb);
    end
  endtask

  // driver
  int unsigned gap_left = 0;
  int unsigned in_calm = 0;
  int unsigned hold_left = 0;

  always @(posedge clk) begin : drv
    link_item_t nxt;
    logic       v;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      v = in_valid;
      if (in_valid && !in_stall) begin
        framer_predict(in_kind, in_rx_byte, in_rx_last);
        v = 1'b0;
      end
      if (!v) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_items.size() > 0) begin
          if (pending_items[0].hold && tx_expected.size() > 0) begin
            hold_left = 4;
          end else if (pending_items[0].hold && hold_left > 0) begin
            hold_left--;
          end else begin
            nxt = pending_items.pop_front();
            in_kind    <= nxt.kind;
            in_rx_byte <= nxt.data;
            in_rx_last <= nxt.last;
            v = 1'b1;
            if (in_calm > 0) begin
              in_calm--;
              gap_left = 0;
            end else begin
              if ($urandom_range(0, 99) < 4) in_calm = $urandom_range(20, 60);
              gap_left = pick_gap();
            end
          end
        end
      end
      in_valid <= v;
    end
  end

  // monitor
  int unsigned stall_left = 0;
  int unsigned out_calm = 0;

  always @(posedge clk) begin : mon
    frame_byte_t want;
    logic        s;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (tx_expected.size() == 0) begin
          $error("unexpected result: tx_byte=%02h frame_end=%0b", out_tx_byte, out_frame_end);
          errors++;
        end else begin
          want = tx_expected.pop_front();
          if (out_tx_byte !== want.tx_byte) begin
            $error("tx_byte: expected %02h, actual %02h", want.tx_byte, out_tx_byte);
            errors++;
          end
          if (out_frame_end !== want.frame_end) begin
            $error("frame_end: expected %0b, actual %0b", want.frame_end, out_frame_end);
            errors++;
          end
        end
      end
      s = 1'b0;
      if (stall_left > 0) begin
        stall_left--;
        s = 1'b1;
      end else if (out_calm > 0) begin
        out_calm--;
      end else if ($urandom_range(0, 99) < 3) begin
        out_calm = $urandom_range(20, 80);
      end else if ($urandom_range(0, 99) < 30) begin
        stall_left = pick_gap();
      end
      out_stall <= s;
    end
  end

  // watchdog
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_item(input logic kind, input logic [7:0] data, input logic last);
    link_item_t it;
    it.kind = kind;
    it.data = data;
    it.last = last;
    it.hold = hold_next;
    hold_next = 1'b0;
    pending_items.push_back(it);
    queued_items++;
  endtask

  task automatic queue_tx(input int n);
    repeat (n) queue_item(KIND_TX, 8'($urandom), 1'($urandom));
  endtask

  task automatic queue_packet(input int len, input bit mix_tx);
    for (int i = 0; i < len; i++) begin
      if (mix_tx && $urandom_range(0, 99) < 20) queue_tx($urandom_range(1, 3));
      queue_item(KIND_RX, 8'($urandom), (i == len - 1));
    end
  endtask

  task automatic drain_ring();
    forever begin
      while (pending_items.size() > 0 || in_valid) @(negedge clk);
      if (wr_ptr == rd_ptr && phase == FR_IDLE) break;
      queue_tx(4);
    end
  endtask

  initial begin : stim
    int r;
    int len;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    queue_tx(2);
    queue_item(KIND_RX, 8'h00, 1'b1);
    queue_item(KIND_RX, 8'hFF, 1'b0);
    queue_item(KIND_RX, 8'h80, 1'b1);
    queue_item(KIND_RX, 8'h7F, 1'b1);
    queue_tx(18);

    hold_next = 1'b1;
    queue_packet(PAYLOAD_MAX, 1'b0);
    queue_packet(PAYLOAD_MAX + 1, 1'b0);
    queue_tx(8);

    // fill the ring, then overflow it
    drain_ring();
    hold_next = 1'b1;
    for (int i = 0; i < SLOTS + 1; i++) queue_packet(1, 1'b0);
    queue_packet(2, 1'b0);
    queue_tx(7);
    queue_packet(3, 1'b0);
    drain_ring();

    queued_items = 0;
    while (queued_items < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        r = $urandom_range(0, 99);
        if (r < 70)      len = $urandom_range(1, 8);
        else if (r < 88) len = $urandom_range(9, PAYLOAD_MAX - 1);
        else if (r < 95) len = PAYLOAD_MAX;
        else             len = $urandom_range(PAYLOAD_MAX + 1, PAYLOAD_MAX + 4);
        queue_packet(len, 1'b1);
      end else if (r < 95) begin
        queue_tx($urandom_range(1, 12));
      end else begin
        drain_ring();
        queue_tx($urandom_range(1, 3));
      end
    end

    drain_ring();
    while (tx_expected.size() > 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (errors == 0 && tx_expected.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
